// ----- design/psscw_pkg.sv -----
// psscw_pkg: shared widths, constants and sideband types of the particle step pipeline
`timescale 1ns / 1ps

package psscw_pkg;

    // field widths
    localparam int POS_W      = 16;
    localparam int VEL_W      = 16;
    localparam int SPD_W      = 8;
    localparam int DT_W       = 10;
    localparam int EXT_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_HEIGHT = 1'd1;
    localparam logic [EXT_W-1:0]     RST_FIELD_WIDTH  = 8'd64;
    localparam logic [EXT_W-1:0]     RST_FIELD_HEIGHT = 8'd32;

    // square root: 48-bit radicand (squared magnitude with 16 fraction bits)
    localparam int M2_W        = 32;
    localparam int RAD_W       = 48;
    localparam int ROOT_W      = 24;
    localparam int REM_W       = 27;
    localparam int SQRT_STAGES = ROOT_W;

    // divider: numerator before the 8-bit shift, shifted dividend, divisor, quotient
    localparam int NUM_W = 38;
    localparam int DIV_W = 47;
    localparam int DEN_W = 35;
    localparam int QUO_W = 13;

    // scaled speed and products
    localparam int SPS_W = 12;
    localparam int AXS_W = 28;
    localparam int SS_W  = 24;
    localparam int SQ_W  = 31;

    // time step scale 2000 for the grow branch
    localparam logic [10:0] GROW_DEN = 11'd2000;

    // division by 125 through a reciprocal: floor(x/125) = (x*RECIP_125) >> 34 for x < 2^27
    localparam int             MAG_W       = 27;
    localparam int             RECIP_W     = 28;
    localparam logic [27:0]    RECIP_125   = 28'd137438954;
    localparam int             RECIP_SHIFT = 34;
    localparam logic [26:0]    ROUND_125   = 27'd62;

    typedef struct packed {
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic [DT_W-1:0]         dt;
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic                    over;
        logic                    zero;
    } t_side;

    typedef struct packed {
        t_side             base;
        logic [NUM_W-1:0]  num_x;
        logic [NUM_W-1:0]  num_y;
    } t_sqrt_side;

endpackage

// ----- design/psscw_if.sv -----
// psscw_if: valid/ready channel interfaces for items, results and register writes
`timescale 1ns / 1ps

interface psscw_in_if;
    import psscw_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic [SPD_W-1:0]        speed_limit;
    logic [DT_W-1:0]         elapsed_ms;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, speed_limit, elapsed_ms,
                    input ready);
    modport sink (input valid, pos_x, pos_y, vel_x, vel_y, speed_limit, elapsed_ms,
                  output ready);
endinterface

interface psscw_out_if;
    import psscw_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [POS_W-1:0]        next_x;
    logic [POS_W-1:0]        next_y;
    logic signed [VEL_W-1:0] next_vx;
    logic signed [VEL_W-1:0] next_vy;

    modport source (output valid, next_x, next_y, next_vx, next_vy, input ready);
    modport sink (input valid, next_x, next_y, next_vx, next_vy, output ready);
endinterface

interface psscw_cfg_if;
    import psscw_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/psscw_sqrt.sv -----
// psscw_sqrt: pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module psscw_sqrt
    import psscw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [M2_W-1:0]   i_m2,
    input  t_sqrt_side        i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_sqrt_side        o_side
);

    logic [SQRT_STAGES-1:0] r_valid;
    logic [REM_W-1:0]       r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0]      r_root [SQRT_STAGES];
    logic [RAD_W-1:0]       r_rad  [SQRT_STAGES];
    t_sqrt_side             r_side [SQRT_STAGES];

    logic [REM_W-1:0]       n_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0]      n_root [SQRT_STAGES];
    logic [RAD_W-1:0]       n_rad  [SQRT_STAGES];
    logic [REM_W-1:0]       w_rem_p  [SQRT_STAGES];
    logic [ROOT_W-1:0]      w_root_p [SQRT_STAGES];
    logic [RAD_W-1:0]       w_rad_p  [SQRT_STAGES];
    logic [REM_W-1:0]       w_rem_t  [SQRT_STAGES];
    logic [REM_W-1:0]       w_trial  [SQRT_STAGES];

    always_comb begin
        for (int k = 0; k < SQRT_STAGES; k++) begin
            if (k == 0) begin
                w_rem_p[k]  = '0;
                w_root_p[k] = '0;
                w_rad_p[k]  = {i_m2, {(RAD_W-M2_W){1'b0}}};
            end else begin
                w_rem_p[k]  = r_rem[k-1];
                w_root_p[k] = r_root[k-1];
                w_rad_p[k]  = r_rad[k-1];
            end
            // bring down the next two radicand bits, try root*4+1
            w_rem_t[k] = {w_rem_p[k][REM_W-3:0], w_rad_p[k][RAD_W-1 -: 2]};
            w_trial[k] = {1'b0, w_root_p[k], 2'b01};
            if (w_rem_t[k] >= w_trial[k]) begin
                n_rem[k]  = w_rem_t[k] - w_trial[k];
                n_root[k] = {w_root_p[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = w_rem_t[k];
                n_root[k] = {w_root_p[k][ROOT_W-2:0], 1'b0};
            end
            n_rad[k] = {w_rad_p[k][RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[SQRT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_valid = r_valid[SQRT_STAGES-1];
    assign o_root  = r_root[SQRT_STAGES-1];
    assign o_side  = r_side[SQRT_STAGES-1];

endmodule

// ----- design/psscw_div.sv -----
// psscw_div: two-lane pipelined restoring divider with a shared divisor
`timescale 1ns / 1ps

module psscw_div
    import psscw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DIV_W-1:0] i_num_x,
    input  logic [DIV_W-1:0] i_num_y,
    input  logic [DEN_W-1:0] i_den,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [QUO_W-1:0] o_quo_x,
    output logic [QUO_W-1:0] o_quo_y,
    output t_side            o_side
);

    logic [QUO_W-1:0] r_valid;
    logic [DIV_W-1:0] r_rem_x [QUO_W];
    logic [DIV_W-1:0] r_rem_y [QUO_W];
    logic [QUO_W-1:0] r_q_x   [QUO_W];
    logic [QUO_W-1:0] r_q_y   [QUO_W];
    logic [DEN_W-1:0] r_den   [QUO_W];
    t_side            r_side  [QUO_W];

    logic [DIV_W-1:0] n_rem_x [QUO_W];
    logic [DIV_W-1:0] n_rem_y [QUO_W];
    logic [QUO_W-1:0] n_q_x   [QUO_W];
    logic [QUO_W-1:0] n_q_y   [QUO_W];
    logic [DIV_W-1:0] w_rx    [QUO_W];
    logic [DIV_W-1:0] w_ry    [QUO_W];
    logic [QUO_W-1:0] w_qx    [QUO_W];
    logic [QUO_W-1:0] w_qy    [QUO_W];
    logic [DEN_W-1:0] w_den   [QUO_W];
    logic [DIV_W-1:0] w_dsh   [QUO_W];

    always_comb begin
        for (int j = 0; j < QUO_W; j++) begin
            if (j == 0) begin
                w_rx[j]  = i_num_x;
                w_ry[j]  = i_num_y;
                w_qx[j]  = '0;
                w_qy[j]  = '0;
                w_den[j] = i_den;
            end else begin
                w_rx[j]  = r_rem_x[j-1];
                w_ry[j]  = r_rem_y[j-1];
                w_qx[j]  = r_q_x[j-1];
                w_qy[j]  = r_q_y[j-1];
                w_den[j] = r_den[j-1];
            end
            // divisor aligned to the quotient bit of this stage, msb first
            w_dsh[j] = DIV_W'(w_den[j]) << (QUO_W - 1 - j);
            if (w_rx[j] >= w_dsh[j]) begin
                n_rem_x[j] = w_rx[j] - w_dsh[j];
                n_q_x[j]   = {w_qx[j][QUO_W-2:0], 1'b1};
            end else begin
                n_rem_x[j] = w_rx[j];
                n_q_x[j]   = {w_qx[j][QUO_W-2:0], 1'b0};
            end
            if (w_ry[j] >= w_dsh[j]) begin
                n_rem_y[j] = w_ry[j] - w_dsh[j];
                n_q_y[j]   = {w_qy[j][QUO_W-2:0], 1'b1};
            end else begin
                n_rem_y[j] = w_ry[j];
                n_q_y[j]   = {w_qy[j][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QUO_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < QUO_W; j++) begin
                r_rem_x[j] <= n_rem_x[j];
                r_rem_y[j] <= n_rem_y[j];
                r_q_x[j]   <= n_q_x[j];
                r_q_y[j]   <= n_q_y[j];
                r_den[j]   <= w_den[j];
                r_side[j]  <= (j == 0) ? i_side : r_side[j-1];
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_quo_x = r_q_x[QUO_W-1];
    assign o_quo_y = r_q_y[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

// ----- design/psscw_move.sv -----
// psscw_move: one axis of position advance, single wrap and clamp, four stages
`timescale 1ns / 1ps

module psscw_move
    import psscw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [POS_W-1:0]        i_pos,
    input  logic signed [VEL_W-1:0] i_vel,
    input  logic [DT_W-1:0]         i_dt,
    input  logic [EXT_W-1:0]        i_extent,
    output logic                    o_valid,
    output logic [POS_W-1:0]        o_pos,
    output logic signed [VEL_W-1:0] o_vel
);

    localparam int PHI_W = MAG_W - 14 + RECIP_W;
    localparam int PLO_W = 14 + RECIP_W;
    localparam int SUM_W = MAG_W + RECIP_W;
    localparam int D_W   = SUM_W - RECIP_SHIFT;
    localparam int P_W   = 22;
    localparam int XE_W  = EXT_W + 1 + 8;

    logic [3:0] r_valid;
    logic signed [VEL_W-1:0] r_vel [4];
    logic [POS_W-1:0] r_pos [2];
    logic             r_neg [2];

    logic [MAG_W-1:0]  r_mag;
    logic [PHI_W-1:0]  r_pp_hi;
    logic [PLO_W-1:0]  r_pp_lo;
    logic signed [P_W-1:0] r_p;
    logic [POS_W-1:0]  r_out;

    logic [VEL_W-1:0]      w_abs;
    logic [MAG_W-2:0]      w_prod;
    logic [MAG_W-1:0]      w_x;
    logic [SUM_W-1:0]      w_sum;
    logic [D_W-1:0]        w_d;
    logic signed [P_W-1:0] w_base;
    logic signed [P_W-1:0] w_dd;
    logic [XE_W-1:0]       w_ext;
    logic signed [P_W-1:0] w_ext_s;
    logic signed [P_W-1:0] w_wrap;
    logic [POS_W-1:0]      n_out;

    // stage 0: |v| * dt * 2
    assign w_abs  = i_vel[VEL_W-1] ? VEL_W'(-i_vel) : VEL_W'(i_vel);
    assign w_prod = w_abs * i_dt;

    // stage 1: round to nearest by 125 via reciprocal, split in two partial products
    assign w_x = r_mag + ROUND_125;

    // stage 2: sum of partials, signed displacement added to the position
    assign w_sum  = ({r_pp_hi, 14'b0}) + SUM_W'(r_pp_lo);
    assign w_d    = w_sum[SUM_W-1 -: D_W];
    assign w_base = P_W'({1'b0, r_pos[1]});
    assign w_dd   = P_W'({1'b0, w_d});

    // stage 3: extent in Q8.8, zero register means the full 256 pixels
    assign w_ext   = (i_extent == '0) ? {1'b1, {(XE_W-1){1'b0}}} : {1'b0, i_extent, 8'b0};
    assign w_ext_s = P_W'({1'b0, w_ext});

    always_comb begin
        if (r_p >= w_ext_s) begin
            w_wrap = r_p - w_ext_s;
        end else if (r_p < 0) begin
            w_wrap = r_p + w_ext_s;
        end else begin
            w_wrap = r_p;
        end
        if (w_wrap < 0) begin
            n_out = '0;
        end else if (w_wrap > w_ext_s - 1) begin
            n_out = POS_W'(w_ext_s - 1);
        end else begin
            n_out = POS_W'(w_wrap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag    <= {w_prod, 1'b0};
            r_neg[0] <= i_vel[VEL_W-1];
            r_pos[0] <= i_pos;
            r_vel[0] <= i_vel;

            r_pp_hi  <= w_x[MAG_W-1:14] * RECIP_125;
            r_pp_lo  <= w_x[13:0] * RECIP_125;
            r_neg[1] <= r_neg[0];
            r_pos[1] <= r_pos[0];
            r_vel[1] <= r_vel[0];

            r_p      <= r_neg[1] ? (w_base - w_dd) : (w_base + w_dd);
            r_vel[2] <= r_vel[1];

            r_out    <= n_out;
            r_vel[3] <= r_vel[2];
        end
    end

    assign o_valid  = r_valid[3];
    assign o_pos    = r_out;
    assign o_vel    = r_vel[3];

endmodule

// ----- design/particle_step_speed_clamp_wrap.sv -----
// particle_step_speed_clamp_wrap: top level of the particle speed clamp and wrap pipeline
//
// channel  direction  transfer carries
// i_in     in         pos_x, pos_y, vel_x, vel_y, speed_limit, elapsed_ms
// o_out    out        next_x, next_y, next_vx, next_vy
// i_cfg    in         index (0 field_width, 1 field_height), data
//
// one particle per cycle while the result is not held; stages in order: 3 front
// stages (squares, sum and products, compare), 24 square root stages, 2 divisor
// stages, 13 divider stages, 1 velocity stage and 4 move stages
// synchronous active-low reset clears all valid bits and loads width 64, height 32
// the whole pipeline advances while the result register is empty or being taken;
// a held result freezes every stage, nothing is dropped or repeated
// register writes are taken every cycle and apply to items in flight at the move stage
`timescale 1ns / 1ps

module particle_step_speed_clamp_wrap
    import psscw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    psscw_in_if.sink    i_in,
    psscw_out_if.source o_out,
    psscw_cfg_if.sink   i_cfg
);

    // saturate an 18-bit two's complement sum into the velocity range
    function automatic logic [VEL_W-1:0] sat_vel(input logic [VEL_W+1:0] s);
        logic [VEL_W-1:0] r;
        if (!s[VEL_W+1] && (s[VEL_W:VEL_W-1] != 2'b00)) begin
            r = {1'b0, {(VEL_W-1){1'b1}}};
        end else if (s[VEL_W+1] && (s[VEL_W:VEL_W-1] != 2'b11)) begin
            r = {1'b1, {(VEL_W-1){1'b0}}};
        end else begin
            r = s[VEL_W-1:0];
        end
        return r;
    endfunction

    logic w_en;

    // configuration registers
    logic [EXT_W-1:0] r_field_width;
    logic [EXT_W-1:0] r_field_height;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width  <= RST_FIELD_WIDTH;
            r_field_height <= RST_FIELD_HEIGHT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FIELD_WIDTH:  r_field_width  <= i_cfg.data;
                CFG_FIELD_HEIGHT: r_field_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // global advance: the result register is free or handed over this cycle
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // stage s0: squares, |v|*S and S*S, S being the limit in Q8.4
    logic [SPS_W-1:0]        w_s;
    logic [VEL_W-1:0]        w_abs_x;
    logic [VEL_W-1:0]        w_abs_y;
    logic signed [M2_W-1:0]  w_sq_x;
    logic signed [M2_W-1:0]  w_sq_y;

    assign w_s     = {i_in.speed_limit, 4'b0};
    assign w_abs_x = i_in.vel_x[VEL_W-1] ? VEL_W'(-i_in.vel_x) : VEL_W'(i_in.vel_x);
    assign w_abs_y = i_in.vel_y[VEL_W-1] ? VEL_W'(-i_in.vel_y) : VEL_W'(i_in.vel_y);
    assign w_sq_x  = i_in.vel_x * i_in.vel_x;
    assign w_sq_y  = i_in.vel_y * i_in.vel_y;

    logic             r_s0_valid;
    t_side            r_s0_side;
    logic [SQ_W-1:0]  r_s0_sq_x;
    logic [SQ_W-1:0]  r_s0_sq_y;
    logic [AXS_W-1:0] r_s0_axs_x;
    logic [AXS_W-1:0] r_s0_axs_y;
    logic [SS_W-1:0]  r_s0_ss;

    // stage s1: squared magnitude and grow numerators
    logic             r_s1_valid;
    t_side            r_s1_side;
    logic [M2_W-1:0]  r_s1_m2;
    logic [AXS_W-1:0] r_s1_axs_x;
    logic [AXS_W-1:0] r_s1_axs_y;
    logic [NUM_W-1:0] r_s1_ng_x;
    logic [NUM_W-1:0] r_s1_ng_y;
    logic [SS_W-1:0]  r_s1_ss;

    // stage s2: branch decision and numerator choice
    logic             r_s2_valid;
    t_sqrt_side       r_s2_side;
    logic [M2_W-1:0]  r_s2_m2;
    logic             w_over;
    t_side            w_s2_base;

    assign w_over = r_s1_m2 > M2_W'(r_s1_ss);

    // sideband with the branch flags filled in
    always_comb begin
        w_s2_base      = r_s1_side;
        w_s2_base.over = w_over;
        w_s2_base.zero = (r_s1_m2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_in.valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_side.vx    <= i_in.vel_x;
            r_s0_side.vy    <= i_in.vel_y;
            r_s0_side.dt    <= i_in.elapsed_ms;
            r_s0_side.pos_x <= i_in.pos_x;
            r_s0_side.pos_y <= i_in.pos_y;
            r_s0_side.over  <= 1'b0;
            r_s0_side.zero  <= 1'b0;
            r_s0_sq_x       <= w_sq_x[SQ_W-1:0];
            r_s0_sq_y       <= w_sq_y[SQ_W-1:0];
            r_s0_axs_x      <= w_abs_x * w_s;
            r_s0_axs_y      <= w_abs_y * w_s;
            r_s0_ss         <= w_s * w_s;

            r_s1_side  <= r_s0_side;
            r_s1_m2    <= M2_W'(r_s0_sq_x) + M2_W'(r_s0_sq_y);
            r_s1_axs_x <= r_s0_axs_x;
            r_s1_axs_y <= r_s0_axs_y;
            r_s1_ng_x  <= r_s0_axs_x * r_s0_side.dt;
            r_s1_ng_y  <= r_s0_axs_y * r_s0_side.dt;
            r_s1_ss    <= r_s0_ss;

            r_s2_side.base      <= w_s2_base;
            r_s2_side.num_x     <= w_over ? NUM_W'(r_s1_axs_x) : r_s1_ng_x;
            r_s2_side.num_y     <= w_over ? NUM_W'(r_s1_axs_y) : r_s1_ng_y;
            r_s2_m2             <= r_s1_m2;
        end
    end

    // magnitude with 8 extra fraction bits
    logic              w_sq_valid;
    logic [ROOT_W-1:0] w_root;
    t_sqrt_side        w_sq_side;

    psscw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_valid),
        .i_m2    (r_s2_m2),
        .i_side  (r_s2_side),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // stage d0: Q*2000 for the grow branch
    logic              r_d0_valid;
    t_sqrt_side        r_d0_side;
    logic [ROOT_W-1:0] r_d0_root;
    logic [DEN_W-1:0]  r_d0_dq;

    // stage d1: divisor choice and rounded dividends (num*256 + den/2)
    logic             r_d1_valid;
    t_side            r_d1_side;
    logic [DEN_W-1:0] r_d1_den;
    logic [DIV_W-1:0] r_d1_num_x;
    logic [DIV_W-1:0] r_d1_num_y;
    logic [DEN_W-1:0] w_den;

    assign w_den = r_d0_side.base.over ? DEN_W'(r_d0_root) : r_d0_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_valid <= 1'b0;
            r_d1_valid <= 1'b0;
        end else if (w_en) begin
            r_d0_valid <= w_sq_valid;
            r_d1_valid <= r_d0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d0_side  <= w_sq_side;
            r_d0_root  <= w_root;
            r_d0_dq    <= w_root * GROW_DEN;

            r_d1_side  <= r_d0_side.base;
            r_d1_den   <= w_den;
            r_d1_num_x <= DIV_W'({r_d0_side.num_x, 8'b0}) + DIV_W'(w_den >> 1);
            r_d1_num_y <= DIV_W'({r_d0_side.num_y, 8'b0}) + DIV_W'(w_den >> 1);
        end
    end

    logic             w_dv_valid;
    logic [QUO_W-1:0] w_quo_x;
    logic [QUO_W-1:0] w_quo_y;
    t_side            w_dv_side;

    psscw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d1_valid),
        .i_num_x (r_d1_num_x),
        .i_num_y (r_d1_num_y),
        .i_den   (r_d1_den),
        .i_side  (r_d1_side),
        .o_valid (w_dv_valid),
        .o_quo_x (w_quo_x),
        .o_quo_y (w_quo_y),
        .o_side  (w_dv_side)
    );

    // stage v0: new velocity; quotient takes the sign of the velocity
    logic [VEL_W+1:0] w_qx;
    logic [VEL_W+1:0] w_qy;
    logic [VEL_W-1:0] n_vx;
    logic [VEL_W-1:0] n_vy;

    assign w_qx = w_dv_side.vx[VEL_W-1] ? ((VEL_W+2)'(0) - (VEL_W+2)'(w_quo_x))
                                        : (VEL_W+2)'(w_quo_x);
    assign w_qy = w_dv_side.vy[VEL_W-1] ? ((VEL_W+2)'(0) - (VEL_W+2)'(w_quo_y))
                                        : (VEL_W+2)'(w_quo_y);

    always_comb begin
        if (w_dv_side.zero) begin
            n_vx = w_dv_side.vx;
            n_vy = w_dv_side.vy;
        end else if (w_dv_side.over) begin
            n_vx = w_qx[VEL_W-1:0];
            n_vy = w_qy[VEL_W-1:0];
        end else begin
            n_vx = sat_vel({{2{w_dv_side.vx[VEL_W-1]}}, w_dv_side.vx} + w_qx);
            n_vy = sat_vel({{2{w_dv_side.vy[VEL_W-1]}}, w_dv_side.vy} + w_qy);
        end
    end

    logic                    r_v0_valid;
    logic signed [VEL_W-1:0] r_v0_vx;
    logic signed [VEL_W-1:0] r_v0_vy;
    logic [POS_W-1:0]        r_v0_pos_x;
    logic [POS_W-1:0]        r_v0_pos_y;
    logic [DT_W-1:0]         r_v0_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0_valid <= 1'b0;
        end else if (w_en) begin
            r_v0_valid <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v0_vx    <= n_vx;
            r_v0_vy    <= n_vy;
            r_v0_pos_x <= w_dv_side.pos_x;
            r_v0_pos_y <= w_dv_side.pos_y;
            r_v0_dt    <= w_dv_side.dt;
        end
    end

    // move, wrap and clamp per axis; the last stage is the result register
    psscw_move u_move_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_v0_valid),
        .i_pos    (r_v0_pos_x),
        .i_vel    (r_v0_vx),
        .i_dt     (r_v0_dt),
        .i_extent (r_field_width),
        .o_valid  (o_out.valid),
        .o_pos    (o_out.next_x),
        .o_vel    (o_out.next_vx)
    );

    psscw_move u_move_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_v0_valid),
        .i_pos    (r_v0_pos_y),
        .i_vel    (r_v0_vy),
        .i_dt     (r_v0_dt),
        .i_extent (r_field_height),
        .o_valid  (),
        .o_pos    (o_out.next_y),
        .o_vel    (o_out.next_vy)
    );

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    // an accepted particle always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_s0_valid)
        else $error("accepted particle lost at entry");

    // a held result backs up to the input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result stalled");

    // a held result keeps its velocity through the stall
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(o_out.next_vx) && $stable(o_out.next_vy))
        else $error("stalled velocity changed");

endmodule
